// ===== rtl/sliding_window_frame_sync_fifo_defines.svh =====
// assertion macros for the sliding window frame sync fifo checker
// no dependencies; included by the checker file
`ifndef SLIDING_WINDOW_FRAME_SYNC_FIFO_DEFINES_SVH
`define SLIDING_WINDOW_FRAME_SYNC_FIFO_DEFINES_SVH

// checked only while out of reset
`define SWFS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define SWFS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/swfs_pkg.sv =====
// shared types, constants and helpers of the sliding window frame sync fifo
// no dependencies; used by every rtl file of the block
package swfs_pkg;

  localparam int unsigned FIFO_DEPTH  = 128;
  localparam int unsigned FRAME_LEN   = 8;
  localparam int unsigned PTR_W       = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W       = $clog2(FRAME_LEN);
  localparam int unsigned CMDQ_DEPTH  = 2;
  localparam int unsigned CMDQ_PTR_W  = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
  localparam logic [7:0]  SYNC_BYTE_RST = 8'h1B;

  typedef enum logic {
    KIND_RX    = 1'b0,
    KIND_DRAIN = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_FRAME    = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  typedef struct packed {
    op_e    op;
    frame_t frame;
  } cmd_t;

  typedef logic [PTR_W-1:0] ptr_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

// ===== rtl/sliding_window_frame_sync_fifo.sv =====
// Sliding window frame sync with a byte ring fifo, top level.
// Depends on swfs_pkg, swfs_front, swfs_cmd_fifo and swfs_back.
//
// Input stream: tuser = kind (0 received byte, 1 drain one frame), tdata = received byte.
// A received byte shifts an 8-byte window; when the oldest byte equals the sync byte and
// the newest equals the 8-bit sum of the other seven, the frame is queued for storage
// and the window clears. A drain request queues a pop of one whole frame.
// Output stream: tdata = frame byte, tlast = last result of a request,
// tuser = status (0 frame byte, 1 frame dropped on full fifo, 2 no frame waiting).
// Received bytes are taken one per cycle while the two-entry command queue has room.
// The back end runs one command at a time on a single-port-write, single-port-read
// byte memory: a stored frame takes 8 writes, a drain 8 reads (one byte out per cycle
// while the output is not stalled), an overflow or empty report a single result.
// A drain goes via queue, S_READ, stage-two and output registers; reports skip S_READ.
// A stalled receiver holds the output register; the back end keeps at most one more
// result in flight, then waits, and the front end stops once the queue is full.
// Reset clears the window, pointers, queue and output valid; the sync byte resets to 0x1B.
// cfg_we_i writes the sync byte register.
module sliding_window_frame_sync_fifo (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic       s_axis_tuser,   // [0] kind
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  output logic [1:0] m_axis_tuser    // [1:0] status
);

  swfs_pkg::cmd_t push_cmd, head_cmd;
  logic           cmd_push, cmd_full, cmd_pop, cmd_valid;

  swfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_kind_i   (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .in_ready_o  (s_axis_tready),
    .cmd_full_i  (cmd_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (push_cmd)
  );

  swfs_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (push_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (head_cmd)
  );

  swfs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (head_cmd),
    .cmd_pop_o    (cmd_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_status_o (m_axis_tuser)
  );

endmodule

// ===== rtl/swfs_front.sv =====
// front end: start byte register, sliding window and frame check
// depends on swfs_pkg; pushes store and drain commands to swfs_cmd_fifo
module swfs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_kind_i,
  input  logic [7:0]       in_byte_i,
  output logic             in_ready_o,
  input  logic             cmd_full_i,
  output logic             cmd_push_o,
  output swfs_pkg::cmd_t   cmd_o
);

  logic [7:0]       start_q;
  swfs_pkg::frame_t window_q, window_d;
  swfs_pkg::frame_t shifted;
  logic [7:0]       sum;
  logic             frame_ok;
  logic             accept;

  assign in_ready_o = !cmd_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    shifted = {in_byte_i, window_q[swfs_pkg::FRAME_LEN-1:1]};
    sum     = '0;
    for (int i = 0; i < swfs_pkg::FRAME_LEN - 1; i++) begin
      sum = sum + shifted[i];
    end
    frame_ok = (shifted[0] == start_q) && (sum == shifted[swfs_pkg::FRAME_LEN-1]);
  end

  always_comb begin
    window_d   = window_q;
    cmd_push_o = 1'b0;
    cmd_o.op   = swfs_pkg::OP_DRAIN;
    cmd_o.frame = shifted;
    if (accept) begin
      if (swfs_pkg::kind_e'(in_kind_i) == swfs_pkg::KIND_DRAIN) begin
        cmd_push_o = 1'b1;
      end else if (frame_ok) begin
        cmd_push_o = 1'b1;
        cmd_o.op   = swfs_pkg::OP_STORE;
        window_d   = '0;
      end else begin
        window_d = shifted;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= swfs_pkg::SYNC_BYTE_RST;
      window_q <= '0;
    end else begin
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
      end
      window_q <= window_d;
    end
  end

endmodule

// ===== rtl/swfs_cmd_fifo.sv =====
// short command queue between the front and back ends
// depends on swfs_pkg
module swfs_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  swfs_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output swfs_pkg::cmd_t cmd_o
);

  swfs_pkg::cmd_t                       entry_q [swfs_pkg::CMDQ_DEPTH];
  logic [swfs_pkg::CMDQ_PTR_W-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [swfs_pkg::CMDQ_CNT_W-1:0]      cnt_q, cnt_d;

  function automatic logic [swfs_pkg::CMDQ_PTR_W-1:0] qinc(
    input logic [swfs_pkg::CMDQ_PTR_W-1:0] p
  );
    qinc = (p == swfs_pkg::CMDQ_PTR_W'(swfs_pkg::CMDQ_DEPTH - 1)) ?
           '0 : p + swfs_pkg::CMDQ_PTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == swfs_pkg::CMDQ_CNT_W'(swfs_pkg::CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = entry_q[rd_q];

  always_comb begin
    wr_d  = push_i ? qinc(wr_q) : wr_q;
    rd_d  = pop_i  ? qinc(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + swfs_pkg::CMDQ_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - swfs_pkg::CMDQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/swfs_back.sv =====
// back end: byte ring fifo memory, pointers, store/drain sequencer, output register
// depends on swfs_pkg; takes commands from swfs_cmd_fifo
module swfs_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  swfs_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o,
  output logic [1:0]     out_status_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WRITE = 3'b010,
    S_READ  = 3'b100
  } state_e;

  state_e                        state_q, state_d;
  swfs_pkg::ptr_t                wptr_q, wptr_d, rptr_q, rptr_d;
  logic [swfs_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  swfs_pkg::frame_t              frame_q, frame_d;
  logic [7:0]                    mem [swfs_pkg::FIFO_DEPTH];
  logic [7:0]                    rdata_q;
  logic                          s2_valid_q, s2_last_q;
  swfs_pkg::status_e             s2_status_q;
  logic                          out_valid_q, out_last_q;
  logic [7:0]                    out_byte_q;
  swfs_pkg::status_e             out_status_q;
  logic                          out_free, issue_ok, issue, iss_last;
  swfs_pkg::status_e             iss_status;
  logic                          wr_en, rd_en, at_last;
  logic [swfs_pkg::PTR_W:0]      used_wide;
  swfs_pkg::ptr_t                used;
  logic                          has_room, has_frame;

  assign out_free = !out_valid_q || out_ready_i;
  assign issue_ok = !s2_valid_q || out_free;
  assign at_last  = (cnt_q == swfs_pkg::CNT_W'(swfs_pkg::FRAME_LEN - 1));

  always_comb begin
    if (wptr_q >= rptr_q) begin
      used_wide = {1'b0, wptr_q} - {1'b0, rptr_q};
    end else begin
      used_wide = {1'b0, wptr_q} + (swfs_pkg::PTR_W + 1)'(swfs_pkg::FIFO_DEPTH)
                  - {1'b0, rptr_q};
    end
    used      = used_wide[swfs_pkg::PTR_W-1:0];
    has_room  = used <= swfs_pkg::PTR_W'(swfs_pkg::FIFO_DEPTH - 1 - swfs_pkg::FRAME_LEN);
    has_frame = used >= swfs_pkg::PTR_W'(swfs_pkg::FRAME_LEN);
  end

  always_comb begin
    state_d    = state_q;
    wptr_d     = wptr_q;
    rptr_d     = rptr_q;
    cnt_d      = cnt_q;
    frame_d    = frame_q;
    cmd_pop_o  = 1'b0;
    issue      = 1'b0;
    iss_last   = 1'b1;
    iss_status = swfs_pkg::ST_FRAME;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            swfs_pkg::OP_STORE: begin
              if (has_room) begin
                cmd_pop_o = 1'b1;
                frame_d   = cmd_i.frame;
                cnt_d     = '0;
                state_d   = S_WRITE;
              end else if (issue_ok) begin
                cmd_pop_o  = 1'b1;
                issue      = 1'b1;
                iss_status = swfs_pkg::ST_OVERFLOW;
              end
            end
            swfs_pkg::OP_DRAIN: begin
              if (has_frame) begin
                cmd_pop_o = 1'b1;
                cnt_d     = '0;
                state_d   = S_READ;
              end else if (issue_ok) begin
                cmd_pop_o  = 1'b1;
                issue      = 1'b1;
                iss_status = swfs_pkg::ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        frame_d = {8'h00, frame_q[swfs_pkg::FRAME_LEN-1:1]};
        wptr_d  = swfs_pkg::ptr_inc(wptr_q);
        cnt_d   = cnt_q + swfs_pkg::CNT_W'(1);
        if (at_last) begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        if (issue_ok) begin
          rd_en    = 1'b1;
          issue    = 1'b1;
          iss_last = at_last;
          rptr_d   = swfs_pkg::ptr_inc(rptr_q);
          cnt_d    = cnt_q + swfs_pkg::CNT_W'(1);
          if (at_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wptr_q      <= '0;
      rptr_q      <= '0;
      cnt_q       <= '0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      cnt_q   <= cnt_d;
      if (issue) begin
        s2_valid_q <= 1'b1;
      end else if (out_free) begin
        s2_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    if (wr_en) begin
      mem[wptr_q] <= frame_q[0];
    end
    if (rd_en) begin
      rdata_q <= mem[rptr_q];
    end
    if (issue) begin
      s2_last_q   <= iss_last;
      s2_status_q <= iss_status;
    end
    if (out_free && s2_valid_q) begin
      out_byte_q   <= (s2_status_q == swfs_pkg::ST_FRAME) ? rdata_q : 8'h00;
      out_last_q   <= s2_last_q;
      out_status_q <= s2_status_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign out_last_o   = out_last_q;
  assign out_status_o = out_status_q;

endmodule

// ===== rtl/swfs_checker.sv =====
// port-level checker for sliding_window_frame_sync_fifo, bound to the top level
// depends on swfs_pkg and sliding_window_frame_sync_fifo_defines.svh
`include "sliding_window_frame_sync_fifo_defines.svh"

module swfs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [1:0] m_axis_tuser
);

  logic        out_xfer;
  logic        is_frame_byte;
  logic        out_stall;
  logic [10:0] out_word;
  logic        report;
  logic        zero_last;
  logic        mid_run;

  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign is_frame_byte = (m_axis_tuser == swfs_pkg::ST_FRAME);
  assign out_stall     = m_axis_tvalid && !m_axis_tready;
  assign out_word      = {m_axis_tuser, m_axis_tlast, m_axis_tdata};
  assign report        = m_axis_tvalid && !is_frame_byte;
  assign zero_last     = m_axis_tlast && (m_axis_tdata == 8'h00);
  assign mid_run       = out_xfer && is_frame_byte && !m_axis_tlast;

  `SWFS_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

  `SWFS_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_word), "stalled result changed")

  `SWFS_ASSERT(a_report_single, report |-> zero_last, "status report not a single zero result")

  `SWFS_ASSERT(a_run_continues, mid_run |=> !m_axis_tvalid || is_frame_byte, "frame run broken")

endmodule

bind sliding_window_frame_sync_fifo swfs_checker u_checker (.*);
